@@ rtl/core/parl_pkg.sv @@
package parl_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        KIND_CONNECT = 2'd0,
        KIND_CHECK   = 2'd1,
        KIND_FAIL    = 2'd2,
        KIND_SUCCESS = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_CONN_LIMIT    = 2'd1,
        CFG_FAIL_LIMIT    = 2'd2,
        CFG_BAN_LENGTH    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic        family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [63:0] window_start;
        logic [15:0] attempt_count;
        logic [7:0]  fail_cnt;
        logic [63:0] ban_deadline;
        logic [63:0] last_attempt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic start;
        logic scan;
        logic fetch;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_end;
    } ctrl_sts_t;

endpackage

@@ rtl/core/parl_ram.sv @@
module parl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/core/parl_ctrl.sv @@
module parl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  parl_pkg::ctrl_sts_t   sts,
    output parl_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);
    import parl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
endmodule

@@ rtl/core/parl_datapath.sv @@
module parl_datapath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  parl_pkg::ctrl_cmd_t                cmd,
    output parl_pkg::ctrl_sts_t                sts,
    input  logic [1:0]                         kind,
    input  logic                               is_ipv6,
    input  logic [63:0]                        addr_high,
    input  logic [63:0]                        addr_low,
    input  logic [63:0]                        now,
    input  logic                               cfg_valid,
    input  logic [parl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                        cfg_data,
    output logic                               done,
    output logic                               refused
);
    import parl_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    logic [63:0] win_len_reg, ban_len_reg;
    logic [15:0] conn_lim_reg;
    logic [7:0]  fail_lim_reg;

    kind_t       kind_reg;
    logic        fam_reg;
    logic [63:0] hi_reg, lo_reg, now_reg;

    logic [UW-1:0] used_reg;
    logic [UW-1:0] issue_reg;
    logic          cmp_valid_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic [AW-1:0] vic_idx_reg;
    logic [63:0]   vic_last_reg;
    logic          vic_unb_reg;
    logic [AW-1:0] tgt_reg;
    logic          have_reg, fresh_reg, alloc_reg;
    logic          done_reg, refused_reg;

    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd, base, wr;

    logic issue_more, same, match, cur_unb, take, alloc_kind, room;
    logic tgt_have, tgt_fresh, tgt_alloc;
    logic [AW-1:0] tgt_idx;
    logic refused_next;
    logic [63:0] elapsed;

    parl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr),
        .rdata (ram_rdata)
    );

    assign rd = entry_t'(ram_rdata);

    assign issue_more = (issue_reg < used_reg);
    assign same = (rd.family == fam_reg) &&
                  (fam_reg ? (rd.addr_high == hi_reg && rd.addr_low == lo_reg)
                           : (rd.addr_high[63:32] == hi_reg[63:32]));
    assign match   = cmp_valid_reg && same;
    assign cur_unb = (rd.ban_deadline <= now_reg);
    assign take    = (cmp_idx_reg == '0) ||
                     (cur_unb && (!vic_unb_reg || rd.last_attempt < vic_last_reg));
    assign sts.scan_end = match || (!issue_more && !cmp_valid_reg);

    assign alloc_kind = (kind_reg == KIND_CONNECT) || (kind_reg == KIND_FAIL);
    assign room       = (used_reg < UW'(TABLE_ENTRIES));

    always_comb
    begin
        tgt_idx   = cmp_idx_reg;
        tgt_have  = 1'b0;
        tgt_fresh = 1'b0;
        tgt_alloc = 1'b0;
        priority if (match)
        begin
            tgt_have = 1'b1;
        end
        else if (!alloc_kind)
        begin
            tgt_have = 1'b0;
        end
        else if (room)
        begin
            tgt_idx   = used_reg[AW-1:0];
            tgt_have  = 1'b1;
            tgt_fresh = 1'b1;
            tgt_alloc = 1'b1;
        end
        else if (vic_unb_reg)
        begin
            tgt_idx   = vic_idx_reg;
            tgt_have  = 1'b1;
            tgt_fresh = 1'b1;
        end
    end

    // Entry update; a fresh entry starts from all zeros plus the address.
    always_comb
    begin
        base = rd;
        if (fresh_reg)
        begin
            base           = '0;
            base.family    = fam_reg;
            base.addr_high = hi_reg;
            base.addr_low  = lo_reg;
        end
        wr           = base;
        refused_next = 1'b0;
        elapsed      = now_reg - base.window_start;
        unique case (kind_reg)
            KIND_CONNECT:
            begin
                if (!have_reg)
                begin
                    refused_next = 1'b1;
                end
                else
                begin
                    if (base.window_start == '0 || elapsed >= win_len_reg)
                    begin
                        wr.window_start  = now_reg;
                        wr.attempt_count = '0;
                    end
                    if (wr.attempt_count >= conn_lim_reg)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        wr.attempt_count = wr.attempt_count + 16'd1;
                        wr.last_attempt  = now_reg;
                    end
                end
            end
            KIND_CHECK:
            begin
                if (have_reg)
                begin
                    if (base.ban_deadline > now_reg)
                    begin
                        refused_next = 1'b1;
                    end
                    else if (base.ban_deadline != '0)
                    begin
                        wr.fail_cnt     = '0;
                        wr.ban_deadline = '0;
                    end
                end
            end
            KIND_FAIL:
            begin
                wr.last_attempt = now_reg;
                if (base.fail_cnt != 8'hFF)
                begin
                    wr.fail_cnt = base.fail_cnt + 8'd1;
                end
                if (wr.fail_cnt >= fail_lim_reg)
                begin
                    wr.ban_deadline = now_reg + ban_len_reg;
                end
            end
            KIND_SUCCESS:
            begin
                wr.fail_cnt     = '0;
                wr.ban_deadline = '0;
                if (base.attempt_count != '0)
                begin
                    wr.attempt_count = base.attempt_count - 16'd1;
                end
            end
            default:
            begin
                wr = base;
            end
        endcase
    end

    assign ram_addr = cmd.scan ? issue_reg[AW-1:0] : tgt_reg;
    assign ram_we   = cmd.exec && have_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg   <= 64'd60000000000;
            conn_lim_reg  <= 16'd120;
            fail_lim_reg  <= 8'd5;
            ban_len_reg   <= 64'd300000000000;
            used_reg      <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            refused_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_WINDOW_LENGTH: win_len_reg  <= cfg_data;
                    CFG_CONN_LIMIT:    conn_lim_reg <= cfg_data[15:0];
                    CFG_FAIL_LIMIT:    fail_lim_reg <= cfg_data[7:0];
                    CFG_BAN_LENGTH:    ban_len_reg  <= cfg_data;
                    default:           win_len_reg  <= win_len_reg;
                endcase
            end
            if (cmd.start)
            begin
                issue_reg     <= '0;
                cmp_valid_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                if (issue_more)
                begin
                    cmp_valid_reg <= 1'b1;
                    issue_reg     <= issue_reg + UW'(1);
                end
                else
                begin
                    cmp_valid_reg <= 1'b0;
                end
            end
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                refused_reg <= refused_next;
                if (alloc_reg)
                begin
                    used_reg <= used_reg + UW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg <= kind_t'(kind);
            fam_reg  <= is_ipv6;
            hi_reg   <= addr_high;
            lo_reg   <= addr_low;
            now_reg  <= now;
        end
        if (cmd.scan)
        begin
            if (issue_more)
            begin
                cmp_idx_reg <= issue_reg[AW-1:0];
            end
            if (cmp_valid_reg && !match && take)
            begin
                vic_idx_reg  <= cmp_idx_reg;
                vic_last_reg <= rd.last_attempt;
                vic_unb_reg  <= cur_unb;
            end
            if (sts.scan_end)
            begin
                tgt_reg   <= tgt_idx;
                have_reg  <= tgt_have;
                fresh_reg <= tgt_fresh;
                alloc_reg <= tgt_alloc;
            end
        end
    end

    assign done    = done_reg;
    assign refused = refused_reg;
endmodule

@@ rtl/core/per_address_rate_limiter.sv @@
// Per-address rate limiter with ban. A request is taken when start is high
// and busy is low; one result (refused) follows on the cycle done is high,
// and it must be captured then. Each request walks the address table one
// entry per cycle through a single-port RAM, then reads and rewrites the
// chosen entry, with busy high throughout (the walk stops early when the
// address is found). The result shows as busy falls, in a cycle where the
// next request can already be taken. Configuration writes are always
// ready.
module per_address_rate_limiter #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     kind,
    input  logic                           is_ipv6,
    input  logic [63:0]                    addr_high,
    input  logic [63:0]                    addr_low,
    input  logic [63:0]                    now,
    output logic                           done,
    output logic                           refused,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [parl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);
    import parl_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    parl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    parl_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .kind      (kind),
        .is_ipv6   (is_ipv6),
        .addr_high (addr_high),
        .addr_low  (addr_low),
        .now       (now),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .refused   (refused)
    );
endmodule

@@ rtl/core/parl_checker.sv @@
module parl_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    // a result never shows while a request is still in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done) else $error("busy dropped without result");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result repeated");
endmodule

bind per_address_rate_limiter parl_checker u_parl_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

import parl_pkg::*;

class rate_limit_scoreboard;
    localparam int ENTRIES = 64;
    localparam int NO_ENTRY = -1;

    bit [63:0]   window_len;
    bit [15:0]   conn_limit;
    bit [7:0]    fail_limit;
    bit [63:0]   ban_len;

    int unsigned used;
    bit          fam[ENTRIES];
    bit [63:0]   tag_hi[ENTRIES];
    bit [63:0]   tag_lo[ENTRIES];
    bit [63:0]   win_start[ENTRIES];
    bit [15:0]   conn_count[ENTRIES];
    bit [7:0]    fail_count[ENTRIES];
    bit [63:0]   banned_until[ENTRIES];
    bit [63:0]   last_seen[ENTRIES];

    bit          refusal_q[$];
    int          errors;

    function new();
        window_len = 64'd60000000000;
        conn_limit = 16'd120;
        fail_limit = 8'd5;
        ban_len    = 64'd300000000000;
        used       = 0;
        errors     = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, bit [63:0] value);
        case (idx)
            CFG_WINDOW_LENGTH: window_len = value;
            CFG_CONN_LIMIT:    conn_limit = value[15:0];
            CFG_FAIL_LIMIT:    fail_limit = value[7:0];
            CFG_BAN_LENGTH:    ban_len    = value;
            default: ;
        endcase
    endfunction

    function int find_entry(bit v6, bit [63:0] hi, bit [63:0] lo);
        for (int i = 0; i < used; i++) begin
            if (fam[i] == v6) begin
                if (!v6 && tag_hi[i][63:32] == hi[63:32])
                    return i;
                if (v6 && tag_hi[i] == hi && tag_lo[i] == lo)
                    return i;
            end
        end
        return NO_ENTRY;
    endfunction

    function int claim_entry(bit v6, bit [63:0] hi, bit [63:0] lo, bit [63:0] t);
        int e;
        int v;
        e = find_entry(v6, hi, lo);
        if (e != NO_ENTRY)
            return e;
        if (used < ENTRIES) begin
            e = used;
            used++;
        end
        else begin
            // LRU among unbanned entries, lowest index on ties
            v = 0;
            for (int i = 1; i < ENTRIES; i++) begin
                if (banned_until[i] <= t &&
                    (banned_until[v] > t || last_seen[i] < last_seen[v]))
                    v = i;
            end
            if (banned_until[v] > t)
                return NO_ENTRY;
            e = v;
        end
        fam[e]          = v6;
        tag_hi[e]       = hi;
        tag_lo[e]       = lo;
        win_start[e]    = '0;
        conn_count[e]   = '0;
        fail_count[e]   = '0;
        banned_until[e] = '0;
        last_seen[e]    = '0;
        return e;
    endfunction

    function void note_request(kind_t k, bit v6, bit [63:0] hi, bit [63:0] lo,
                               bit [63:0] t);
        int e;
        bit refuse;
        refuse = 1'b0;
        case (k)
            KIND_CONNECT: begin
                e = claim_entry(v6, hi, lo, t);
                if (e == NO_ENTRY)
                    refuse = 1'b1;
                else begin
                    if (win_start[e] == 0 || t - win_start[e] >= window_len) begin
                        win_start[e]  = t;
                        conn_count[e] = '0;
                    end
                    if (conn_count[e] >= conn_limit)
                        refuse = 1'b1;
                    else begin
                        conn_count[e]++;
                        last_seen[e] = t;
                    end
                end
            end
            KIND_CHECK: begin
                e = find_entry(v6, hi, lo);
                if (e != NO_ENTRY) begin
                    if (banned_until[e] > t)
                        refuse = 1'b1;
                    else if (banned_until[e] != 0) begin
                        fail_count[e]   = '0;
                        banned_until[e] = '0;
                    end
                end
            end
            KIND_FAIL: begin
                e = claim_entry(v6, hi, lo, t);
                if (e != NO_ENTRY) begin
                    last_seen[e] = t;
                    if (fail_count[e] != 8'hFF)
                        fail_count[e]++;
                    if (fail_count[e] >= fail_limit)
                        banned_until[e] = t + ban_len;
                end
            end
            default: begin
                e = find_entry(v6, hi, lo);
                if (e != NO_ENTRY) begin
                    fail_count[e]   = '0;
                    banned_until[e] = '0;
                    if (conn_count[e] != 0)
                        conn_count[e]--;
                end
            end
        endcase
        refusal_q.push_back(refuse);
    endfunction

    function void check_result(bit got);
        bit want;
        if (refusal_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual refused=%0b",
                     $time, got);
            errors++;
            return;
        end
        want = refusal_q.pop_front();
        if (want !== got) begin
            $display("%0t: refused mismatch: expected %0b, actual %0b",
                     $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int TABLE_ENTRIES = 64;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           kind;
    logic                 is_ipv6;
    logic [63:0]          addr_high;
    logic [63:0]          addr_low;
    logic [63:0]          now;
    logic                 done;
    logic                 refused;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    rate_limit_scoreboard refusals;

    int          burst_left;
    bit [63:0]   clock_ns;
    bit [63:0]   pool_hi[100];
    bit [63:0]   pool_lo[100];
    bit          pool_v6[100];

    per_address_rate_limiter #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .is_ipv6   (is_ipv6),
        .addr_high (addr_high),
        .addr_low  (addr_low),
        .now       (now),
        .done      (done),
        .refused   (refused),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            refusals.check_result(refused);
    end

    task automatic send_request(kind_t k, bit v6, bit [63:0] hi, bit [63:0] lo,
                                bit [63:0] t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start     <= 1'b1;
        kind      <= k;
        is_ipv6   <= v6;
        addr_high <= hi;
        addr_low  <= lo;
        now       <= t;
        do
            @(posedge clk);
        while (busy);
        refusals.note_request(k, v6, hi, lo, t);
    endtask

    // hold off until all results are in and the block is quiet
    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (refusals.refusal_q.size() != 0 || busy)
            @(posedge clk);
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
    endtask

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(cfg_idx_t idx, bit [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        refusals.write_reg(idx, value);
    endtask

    task automatic configure(bit [63:0] win, bit [63:0] lim, bit [63:0] flim,
                             bit [63:0] ban);
        drain();
        write_reg(CFG_WINDOW_LENGTH, win);
        write_reg(CFG_CONN_LIMIT, lim);
        write_reg(CFG_FAIL_LIMIT, flim);
        write_reg(CFG_BAN_LENGTH, ban);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_pool(int n);
        for (int i = 0; i < n; i++) begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
            pool_v6[i] = 1'($urandom_range(0, 1));
        end
    endtask

    task automatic random_phase(int count, int pool_n, int max_step);
        int     pick;
        int     r;
        kind_t  k;
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] t;
        fill_pool(pool_n);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, pool_n - 1);
            hi = pool_hi[pick];
            lo = pool_lo[pick];
            if (!pool_v6[pick]) begin
                // IPv4 ignores everything below the top 32 bits
                hi[31:0] = $urandom;
                lo = {$urandom, $urandom};
            end
            r = $urandom_range(0, 99);
            k = (r < 40) ? KIND_CONNECT : (r < 65) ? KIND_CHECK :
                (r < 85) ? KIND_FAIL : KIND_SUCCESS;
            r = $urandom_range(0, 99);
            if (r < 5)
                t = {$urandom, $urandom};
            else if (r < 8)
                t = '1 - $urandom_range(0, 3);
            else begin
                clock_ns = clock_ns + $urandom_range(0, max_step);
                t = clock_ns;
            end
            send_request(k, pool_v6[pick], hi, lo, t);
        end
    endtask

    initial
    begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        bit [63:0] a4;
        bit [63:0] a6h;
        bit [63:0] a6l;
        refusals   = new();
        burst_left = 0;
        clock_ns   = 64'd1000;
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = KIND_CONNECT;
        is_ipv6    = 1'b0;
        addr_high  = '0;
        addr_low   = '0;
        now        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_WINDOW_LENGTH;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: a few requests under reset settings, then tight limits
        a4  = 64'hC0A8_0001_1234_5678;
        a6h = '1;
        a6l = '1;
        send_request(KIND_CONNECT, 1'b0, a4, '0, 64'd5);
        send_request(KIND_CHECK, 1'b1, '0, '0, '0);
        configure(64'd100, 64'd2, 64'd2, 64'd50);
        send_request(KIND_CONNECT, 1'b0, a4, '0, 64'd1000);
        send_request(KIND_CONNECT, 1'b0, {a4[63:32], 32'hFFFF_FFFF}, '1, 64'd1001);
        send_request(KIND_CONNECT, 1'b0, a4, '0, 64'd1002);
        send_request(KIND_SUCCESS, 1'b0, a4, '0, 64'd1002);
        send_request(KIND_CONNECT, 1'b0, a4, '0, 64'd1003);
        send_request(KIND_CONNECT, 1'b0, a4, '0, 64'd1100);
        send_request(KIND_CHECK, 1'b1, a6h, a6l, 64'd1200);
        send_request(KIND_SUCCESS, 1'b1, a6h, a6l, 64'd1200);
        send_request(KIND_FAIL, 1'b1, a6h, a6l, 64'd2000);
        send_request(KIND_FAIL, 1'b1, a6h, a6l, 64'd2001);
        send_request(KIND_CHECK, 1'b1, a6h, a6l, 64'd2010);
        send_request(KIND_CONNECT, 1'b1, a6h, a6l, 64'd2020);
        send_request(KIND_CHECK, 1'b1, a6h, a6l, 64'd2051);
        send_request(KIND_CHECK, 1'b1, a6h, a6l, 64'd2052);
        send_request(KIND_CONNECT, 1'b1, '0, '0, '0);
        send_request(KIND_CONNECT, 1'b1, '0, '0, '0);
        send_request(KIND_CONNECT, 1'b0, '0, '1, '1);
        send_request(KIND_FAIL, 1'b0, '0, '0, '1);
        send_request(KIND_FAIL, 1'b0, '0, '0, '1);
        send_request(KIND_CHECK, 1'b0, '0, '0, '1);
        send_request(KIND_SUCCESS, 1'b0, '0, '0, '1);

        configure(64'd200, 64'd3, 64'd3, 64'd400);
        random_phase(90, 8, 40);
        configure(64'd1, 64'd0, 64'd1, 64'd0);
        random_phase(50, 6, 5);
        configure('1, 64'd65535, 64'd255, '1);
        random_phase(50, 6, 1000);
        configure(64'd500, 64'd4, 64'd0, 64'd300);
        random_phase(40, 6, 50);
        // table overflow with LRU reuse
        configure(64'd1000, 64'd5, 64'd2, 64'd200);
        random_phase(130, 90, 20);

        // every entry banned: new connections refused, failures dropped
        configure(64'd1000, 64'd5, 64'd1, 64'hFFFF_FFFF_0000_0000);
        fill_pool(70);
        for (int i = 0; i < 70; i++) begin
            clock_ns = clock_ns + 1;
            send_request(KIND_FAIL, 1'b1, pool_hi[i], pool_lo[i], clock_ns);
        end
        for (int i = 0; i < 8; i++) begin
            clock_ns = clock_ns + 1;
            send_request(i[0] ? KIND_FAIL : KIND_CONNECT, 1'b1,
                         {$urandom, $urandom}, {$urandom, $urandom}, clock_ns);
        end

        drain();
        if (refusals.errors == 0 && refusals.refusal_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/parl_pkg.sv
rtl/core/parl_ram.sv
rtl/core/parl_ctrl.sv
rtl/core/parl_datapath.sv
rtl/core/per_address_rate_limiter.sv
rtl/core/parl_checker.sv
dv/tb_top.sv
